### rtl/core/bmer_pkg.sv
// Shared types and constants for the binary mask edge refine core
`timescale 1ns / 1ps
`default_nettype none

package bmer_pkg;

   // stream and register port widths
   localparam int REQ_TDATA_W = 16;
   localparam int REQ_TUSER_W = 1;
   localparam int RSP_TDATA_W = 32;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 9;

   // request tdata and tuser layout
   localparam int REQ_IN_AREA_BIT = 0;
   localparam int REQ_ALLOWED_BIT = 1;
   localparam int REQ_OWNER_LSB   = 2;
   localparam int FIELD_OWNER_W   = 8;
   localparam int REQ_PAD_BIT     = 0;

   // result field widths
   localparam int FIELD_POS_W   = 8;
   localparam int RSP_USED_W    = 2 * FIELD_POS_W + 3 + FIELD_OWNER_W;

   // frame and neighbourhood limits
   localparam int MAX_HEIGHT  = 256;
   localparam int HOLLOW_MIN  = 3;
   localparam int SPIKE_MAX   = 1;
   localparam int NBR4_COUNT  = 4;
   localparam int NBR8_COUNT  = 8;

   // register reset values
   localparam logic [CSR_DATA_W-1:0] MAP_WIDTH_RST  = 9'd64;
   localparam logic [CSR_DATA_W-1:0] MAP_HEIGHT_RST = 9'd64;
   localparam logic [7:0]            OWN_INDEX_RST  = 8'd1;

   // register indexes
   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_MAP_WIDTH     = 3'd0,
      CSR_MAP_HEIGHT    = 3'd1,
      CSR_DIAGONAL_MODE = 3'd2,
      CSR_REFINE_TASK   = 3'd3,
      CSR_OWN_INDEX     = 3'd4
   } csr_index_type;

   // refine task codes
   typedef enum logic [1:0] {
      TASK_NONE   = 2'd0,
      TASK_HOLLOW = 2'd1,
      TASK_SPIKE  = 2'd2,
      TASK_EXPAND = 2'd3
   } refine_task_type;

endpackage

`default_nettype wire

### rtl/core/bmer_ram.sv
// Generic simple dual-port RAM with registered read
`timescale 1ns / 1ps
`default_nettype none

module bmer_ram #(
   parameter int DATA_W = 8,
   parameter int DEPTH  = 256,
   localparam int ADDR_W = $clog2(DEPTH)
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [DATA_W-1:0] wr_data,
   input  wire logic              rd_en,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output logic      [DATA_W-1:0] rd_data
);

   logic [DATA_W-1:0] mem_ff [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   // write port, read port returns old data on a same-address collision
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

### rtl/core/binary_mask_edge_refine_core.sv
// Top level: 3x3 mask edge detector and one-pass refiner over a raster stream
//
// Pixels arrive on the req_ stream in raster order, map_height rows of
// map_width pixels, followed by map_width + 1 flush items (tuser set). A
// flush item at the very start of a frame is taken and dropped. Each pixel
// is reported on the rsp_ stream with its inner/outside edge flags and the
// refined mask bit and owner; the report for a pixel leaves with the
// transfer of the item one row and one pixel later in the stream.
// One item is taken every cycle unless a stalled result holds the stream;
// a result passes the window stage, fed by the line buffer RAM's registered
// read, then the result register. The user writes registers through the
// csr_ port only while the stream is idle; the block does not enforce it;
// writing the width or the height restarts the frame at column 0, row 0.
// Reset restores the register defaults (64 x 64, four neighbours, no
// refine task, own index 1) and empties the pipeline; the line buffer is
// not cleared, rows outside the map are masked by position instead.
// When rsp_tready is low the result holds; one more item can still enter
// the window stage, after which req_tready drops until the result leaves.
`timescale 1ns / 1ps
`default_nettype none

module binary_mask_edge_refine_core #(
   parameter int MAX_WIDTH  = 256,
   parameter int OWNER_BITS = 8
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   // request stream
   input  wire logic                                req_tvalid,
   output logic                                     req_tready,
   // [0] in_area, [1] allowed, [9:2] owner, zero fill above
   input  wire logic [bmer_pkg::REQ_TDATA_W-1:0]    req_tdata,
   // [0] is_padding
   input  wire logic [bmer_pkg::REQ_TUSER_W-1:0]    req_tuser,
   // result stream
   output logic                                     rsp_tvalid,
   input  wire logic                                rsp_tready,
   // [7:0] pos_x, [15:8] pos_y, [16] inner_edge, [17] outside_edge,
   // [18] new_in_area, [26:19] new_owner, zero fill above
   output logic      [bmer_pkg::RSP_TDATA_W-1:0]    rsp_tdata,
   // register write port
   input  wire logic                                csr_we,
   input  wire logic [bmer_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  wire logic [bmer_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   localparam int XW = $clog2(MAX_WIDTH);
   localparam int WW = XW + 10;
   localparam int HW = bmer_pkg::CSR_DATA_W;

   typedef struct packed {
      logic                  prev_mask;
      logic                  mask;
      logic                  allowed;
      logic [OWNER_BITS-1:0] owner;
   } line_type;

   typedef struct packed {
      logic                  top;
      logic                  mid;
      logic                  bot;
      logic                  allowed;
      logic [OWNER_BITS-1:0] owner;
   } col_type;

   // configuration registers
   logic [HW-1:0]                 map_width_ff;
   logic [HW-1:0]                 map_height_ff;
   logic                          diag_ff;
   bmer_pkg::refine_task_type     task_ff;
   logic [7:0]                    own_index_ff;
   logic                          pos_restart;

   // effective frame size
   logic [WW-1:0]                 mw_ext;
   logic [WW-1:0]                 w_eff;
   logic [HW-1:0]                 h_eff;

   // input side
   logic                          req_fire;
   logic                          in_pad;
   logic                          in_skip;
   logic                          b_load;
   logic [OWNER_BITS+7:0]         owner_ext;
   logic [XW-1:0]                 x_ff, x_in;
   logic [HW-1:0]                 y_ff, y_in;
   logic [WW-1:0]                 x_ext;

   // window stage
   logic                          b_valid_ff, b_valid_in;
   logic [XW-1:0]                 b_x_ff;
   logic [HW-1:0]                 b_y_ff;
   logic                          b_mask_ff;
   logic                          b_allowed_ff;
   logic [OWNER_BITS-1:0]         b_owner_ff;
   logic                          b_adv;
   logic                          b_fire;
   logic                          byp_hit_ff, byp_hit_in;
   line_type                      byp_data_ff;
   logic [$bits(line_type)-1:0]   ram_rd_data;
   line_type                      line_q;
   line_type                      line_wr;
   col_type                       ctr_col_ff;
   col_type                       left_col_ff;
   col_type                       col_in;
   col_type                       right_col;

   // window decision
   logic [HW:0]                   y10;
   logic [HW:0]                   h10;
   logic                          top_ok, mid_ok, bot_ok;
   logic [2:0]                    n4;
   logic [3:0]                    n8;
   logic                          inner, outer, may_join;
   logic                          new_a;
   logic [OWNER_BITS-1:0]         new_own;
   logic [OWNER_BITS-1:0]         idx;
   logic [OWNER_BITS+7:0]         idx_ext;
   logic [OWNER_BITS+7:0]         new_own_ext;
   logic                          emit;
   logic [WW-1:0]                 bx_ext;
   logic [WW-1:0]                 cx;
   logic [HW-1:0]                 cy;

   // result register
   logic                          out_valid_ff, out_valid_in;
   logic [bmer_pkg::RSP_TDATA_W-1:0] out_data_ff;

   // register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         map_width_ff  <= bmer_pkg::MAP_WIDTH_RST;
         map_height_ff <= bmer_pkg::MAP_HEIGHT_RST;
         diag_ff       <= 1'b0;
         task_ff       <= bmer_pkg::TASK_NONE;
         own_index_ff  <= bmer_pkg::OWN_INDEX_RST;
      end else if (csr_we) begin
         unique case (bmer_pkg::csr_index_type'(csr_index))
            bmer_pkg::CSR_MAP_WIDTH:     map_width_ff  <= csr_wdata;
            bmer_pkg::CSR_MAP_HEIGHT:    map_height_ff <= csr_wdata;
            bmer_pkg::CSR_DIAGONAL_MODE: diag_ff       <= csr_wdata[0];
            bmer_pkg::CSR_REFINE_TASK:   task_ff <= bmer_pkg::refine_task_type'(csr_wdata[1:0]);
            bmer_pkg::CSR_OWN_INDEX:     own_index_ff  <= csr_wdata[7:0];
            default: ;
         endcase
      end
   end

   assign pos_restart = csr_we &&
      ((bmer_pkg::csr_index_type'(csr_index) == bmer_pkg::CSR_MAP_WIDTH) ||
       (bmer_pkg::csr_index_type'(csr_index) == bmer_pkg::CSR_MAP_HEIGHT));

   // clamp width and height into their legal range
   always_comb begin
      mw_ext = {{(WW-HW){1'b0}}, map_width_ff};
      if (mw_ext == '0) begin
         w_eff = WW'(1);
      end else if (mw_ext > WW'(MAX_WIDTH)) begin
         w_eff = WW'(MAX_WIDTH);
      end else begin
         w_eff = mw_ext;
      end
      if (map_height_ff == '0) begin
         h_eff = HW'(1);
      end else if (map_height_ff > HW'(bmer_pkg::MAX_HEIGHT)) begin
         h_eff = HW'(bmer_pkg::MAX_HEIGHT);
      end else begin
         h_eff = map_height_ff;
      end
   end

   // input transfer and frame position
   assign b_adv      = !out_valid_ff || rsp_tready;
   assign b_fire     = b_valid_ff && b_adv;
   assign req_tready = !b_valid_ff || b_adv;
   assign req_fire   = req_tvalid && req_tready;
   assign in_pad     = req_tuser[bmer_pkg::REQ_PAD_BIT];
   assign in_skip    = in_pad && (x_ff == '0) && (y_ff == '0);
   assign b_load     = req_fire && !in_skip;
   assign x_ext      = {{(WW-XW){1'b0}}, x_ff};
   assign owner_ext  = {{OWNER_BITS{1'b0}},
                        req_tdata[bmer_pkg::REQ_OWNER_LSB +: bmer_pkg::FIELD_OWNER_W]};

   always_comb begin
      x_in = x_ff;
      y_in = y_ff;
      if (pos_restart) begin
         x_in = '0;
         y_in = '0;
      end else if (b_load) begin
         if ((x_ff == '0) && ({1'b0, y_ff} >= ({1'b0, h_eff} + (HW+1)'(1)))) begin
            x_in = '0;
            y_in = '0;
         end else if ((x_ext + WW'(1)) >= w_eff) begin
            x_in = '0;
            y_in = y_ff + HW'(1);
         end else begin
            x_in = x_ff + XW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         x_ff <= '0;
         y_ff <= '0;
      end else begin
         x_ff <= x_in;
         y_ff <= y_in;
      end
   end

   // window stage occupancy and line buffer bypass flag
   always_comb begin
      b_valid_in = b_valid_ff;
      if (b_load) begin
         b_valid_in = 1'b1;
      end else if (b_fire) begin
         b_valid_in = 1'b0;
      end
      byp_hit_in = byp_hit_ff;
      if (b_load) begin
         byp_hit_in = b_fire && (b_x_ff == x_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff <= 1'b0;
         byp_hit_ff <= 1'b0;
      end else begin
         b_valid_ff <= b_valid_in;
         byp_hit_ff <= byp_hit_in;
      end
   end

   // window stage payload, padding stands for an all-zero pixel
   always_ff @(posedge clock) begin
      if (b_load) begin
         b_x_ff       <= x_ff;
         b_y_ff       <= y_ff;
         b_mask_ff    <= req_tdata[bmer_pkg::REQ_IN_AREA_BIT] && !in_pad;
         b_allowed_ff <= req_tdata[bmer_pkg::REQ_ALLOWED_BIT] && !in_pad;
         b_owner_ff   <= in_pad ? '0 : owner_ext[OWNER_BITS-1:0];
         byp_data_ff  <= line_wr;
      end
   end

   // line buffer: row above (full pixel) and two rows above (mask only)
   assign line_wr = '{prev_mask: line_q.mask, mask: b_mask_ff,
                      allowed: b_allowed_ff, owner: b_owner_ff};

   bmer_ram #(
      .DATA_W ($bits(line_type)),
      .DEPTH  (MAX_WIDTH)
   ) u_line_ram (
      .clock   (clock),
      .wr_en   (b_fire),
      .wr_addr (b_x_ff),
      .wr_data (line_wr),
      .rd_en   (b_load),
      .rd_addr (x_ff),
      .rd_data (ram_rd_data)
   );

   assign line_q = byp_hit_ff ? byp_data_ff : line_type'(ram_rd_data);

   // new window column, rows outside the map read as outside
   always_comb begin
      y10    = {1'b0, b_y_ff};
      h10    = {1'b0, h_eff};
      top_ok = (b_y_ff >= HW'(2)) && (y10 < (h10 + (HW+1)'(2)));
      mid_ok = (b_y_ff >= HW'(1)) && (y10 < (h10 + (HW+1)'(1)));
      bot_ok = b_y_ff < h_eff;
      col_in = '{top: line_q.prev_mask && top_ok, mid: line_q.mask && mid_ok,
                 bot: b_mask_ff && bot_ok, allowed: line_q.allowed,
                 owner: line_q.owner};
      // at column 0 the centre is the last pixel of the row, nothing to its right
      right_col = (b_x_ff == '0) ? '0 : col_in;
   end

   // window shift, a new row starts with empty columns to the left
   always_ff @(posedge clock) begin
      if (b_fire) begin
         if (b_x_ff == '0) begin
            left_col_ff <= '0;
         end else begin
            left_col_ff <= ctr_col_ff;
         end
         ctr_col_ff <= col_in;
      end
   end

   // neighbour counts and edge flags
   always_comb begin
      n4 = 3'(ctr_col_ff.top) + 3'(ctr_col_ff.bot) +
           3'(left_col_ff.mid) + 3'(right_col.mid);
      n8 = {1'b0, n4} + 4'(left_col_ff.top) + 4'(left_col_ff.bot) +
           4'(right_col.top) + 4'(right_col.bot);
      if (diag_ff) begin
         inner = ctr_col_ff.mid && (n8 < 4'(bmer_pkg::NBR8_COUNT));
         outer = !ctr_col_ff.mid && (n8 != '0);
      end else begin
         inner = ctr_col_ff.mid && (n4 < 3'(bmer_pkg::NBR4_COUNT));
         outer = !ctr_col_ff.mid && (n4 != '0);
      end
   end

   // refine task
   always_comb begin
      idx_ext  = {{OWNER_BITS{1'b0}}, own_index_ff};
      idx      = idx_ext[OWNER_BITS-1:0];
      may_join = outer && ctr_col_ff.allowed &&
                 ((ctr_col_ff.owner == '0) || (ctr_col_ff.owner == idx));
      new_a    = ctr_col_ff.mid;
      new_own  = ctr_col_ff.owner;
      unique case (task_ff)
         bmer_pkg::TASK_HOLLOW: begin
            if (may_join && (n4 >= 3'(bmer_pkg::HOLLOW_MIN))) begin
               new_a   = 1'b1;
               new_own = idx;
            end
         end
         bmer_pkg::TASK_SPIKE: begin
            if (inner && (n4 <= 3'(bmer_pkg::SPIKE_MAX))) begin
               new_a   = 1'b0;
               new_own = '0;
            end
         end
         bmer_pkg::TASK_EXPAND: begin
            if (may_join) begin
               new_a   = 1'b1;
               new_own = idx;
            end
         end
         bmer_pkg::TASK_NONE: ;
         default: ;
      endcase
      new_own_ext = {8'd0, new_own};
   end

   // reported position and whether this item releases a result
   always_comb begin
      bx_ext = {{(WW-XW){1'b0}}, b_x_ff};
      if (b_x_ff == '0) begin
         emit = top_ok;
         cx   = w_eff - WW'(1);
         cy   = b_y_ff - HW'(2);
      end else begin
         emit = mid_ok;
         cx   = bx_ext - WW'(1);
         cy   = b_y_ff - HW'(1);
      end
   end

   // result register
   always_comb begin
      out_valid_in = out_valid_ff && !rsp_tready;
      if (b_fire) begin
         out_valid_in = emit;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (b_fire && emit) begin
         out_data_ff <= {{(bmer_pkg::RSP_TDATA_W - bmer_pkg::RSP_USED_W){1'b0}},
                         new_own_ext[7:0], new_a, outer, inner,
                         cy[bmer_pkg::FIELD_POS_W-1:0], cx[bmer_pkg::FIELD_POS_W-1:0]};
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;

   // column counter never reaches the row width
   assert property (@(posedge clock) disable iff (reset)
      x_ext < w_eff)
      else $error("column counter beyond row width");

   // row counter never passes the last flush row
   assert property (@(posedge clock) disable iff (reset)
      {1'b0, y_ff} <= ({1'b0, h_eff} + (HW+1)'(1)))
      else $error("row counter beyond flush row");

   // a padding item at frame start leaves the position at the origin
   assert property (@(posedge clock) disable iff (reset)
      req_fire && in_skip |=> (x_ff == '0) && (y_ff == '0))
      else $error("leading padding moved the frame position");

   // a new result comes only from an item in the window stage
   assert property (@(posedge clock) disable iff (reset)
      $rose(out_valid_ff) |-> $past(b_valid_ff))
      else $error("result without a window stage item");

endmodule

`default_nettype wire

### bench/mask_edge_checker.sv
// Checker for the mask edge refine core: predicts every pixel report and compares
`timescale 1ns / 1ps

module mask_edge_checker #(
   parameter int MAX_W = 256
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_tvalid,
   input  wire logic                                req_tready,
   // [0] in_area, [1] allowed, [9:2] owner, zero fill above
   input  wire logic [bmer_pkg::REQ_TDATA_W-1:0]    req_tdata,
   // [0] is_padding
   input  wire logic [bmer_pkg::REQ_TUSER_W-1:0]    req_tuser,
   input  wire logic                                rsp_tvalid,
   input  wire logic                                rsp_tready,
   // [7:0] pos_x, [15:8] pos_y, [16] inner_edge, [17] outside_edge,
   // [18] new_in_area, [26:19] new_owner, zero fill above
   input  wire logic [bmer_pkg::RSP_TDATA_W-1:0]    rsp_tdata,
   input  wire logic                                csr_we,
   input  wire logic [bmer_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  wire logic [bmer_pkg::CSR_DATA_W-1:0]     csr_wdata,
   output int                                       fail_total,
   output int                                       reports_waiting
);
   import bmer_pkg::*;

   // result field positions
   localparam int POS_Y_LSB     = FIELD_POS_W;
   localparam int INNER_BIT     = 2 * FIELD_POS_W;
   localparam int OUTSIDE_BIT   = INNER_BIT + 1;
   localparam int NEW_AREA_BIT  = INNER_BIT + 2;
   localparam int NEW_OWNER_LSB = INNER_BIT + 3;

   typedef struct {
      logic [FIELD_POS_W-1:0]   pos_x;
      logic [FIELD_POS_W-1:0]   pos_y;
      logic                     inner_edge;
      logic                     outside_edge;
      logic                     new_in_area;
      logic [FIELD_OWNER_W-1:0] new_owner;
   } pixel_report_t;

   // register copies
   logic [CSR_DATA_W-1:0]    width_reg  = MAP_WIDTH_RST;
   logic [CSR_DATA_W-1:0]    height_reg = MAP_HEIGHT_RST;
   logic                     diag_reg   = 1'b0;
   refine_task_type          refine_reg = TASK_NONE;
   logic [FIELD_OWNER_W-1:0] own_reg    = OWN_INDEX_RST;

   // three line window: rows above, centre and the incoming row
   logic                     mask_above [MAX_W];
   logic                     mask_mid   [MAX_W];
   logic                     mask_low   [MAX_W];
   logic [FIELD_OWNER_W-1:0] owner_mid  [MAX_W];
   logic [FIELD_OWNER_W-1:0] owner_low  [MAX_W];
   logic                     allow_mid  [MAX_W];
   logic                     allow_low  [MAX_W];
   int                       col_pos = 0;
   int                       row_pos = 0;

   pixel_report_t expected_reports [$];
   int            fail_count   = 0;
   int            waiting_copy = 0;

   assign fail_total      = fail_count;
   assign reports_waiting = waiting_copy;

   function automatic int active_width();
      if (width_reg == 0) return 1;
      if (width_reg > MAX_W) return MAX_W;
      return int'(width_reg);
   endfunction

   function automatic int active_height();
      if (height_reg == 0) return 1;
      if (height_reg > MAX_HEIGHT) return MAX_HEIGHT;
      return int'(height_reg);
   endfunction

   // neighbour mask bit, outside the map counts as zero
   function automatic int mask_near(int nx, int ny, int cy);
      if (nx < 0 || nx >= active_width() || ny < 0 || ny >= active_height()) return 0;
      if (ny < cy) return int'(mask_above[nx]);
      if (ny == cy) return int'(mask_mid[nx]);
      return int'(mask_low[nx]);
   endfunction

   // edge flags and refined mask for the centre row pixel at column cx
   function automatic pixel_report_t predict_report(int cx, int cy);
      pixel_report_t rep;
      int            n4;
      int            n8;
      logic          centre;
      logic          inner;
      logic          outer;
      logic          may_join;
      n4 = mask_near(cx, cy - 1, cy) + mask_near(cx, cy + 1, cy)
         + mask_near(cx - 1, cy, cy) + mask_near(cx + 1, cy, cy);
      n8 = n4 + mask_near(cx - 1, cy - 1, cy) + mask_near(cx + 1, cy - 1, cy)
         + mask_near(cx - 1, cy + 1, cy) + mask_near(cx + 1, cy + 1, cy);
      centre = mask_mid[cx];
      if (diag_reg) begin
         inner = centre && (n8 < NBR8_COUNT);
         outer = !centre && (n8 > 0);
      end else begin
         inner = centre && (n4 < NBR4_COUNT);
         outer = !centre && (n4 > 0);
      end
      may_join = outer && allow_mid[cx] && (owner_mid[cx] == 0 || owner_mid[cx] == own_reg);
      rep.pos_x        = FIELD_POS_W'(cx);
      rep.pos_y        = FIELD_POS_W'(cy);
      rep.inner_edge   = inner;
      rep.outside_edge = outer;
      rep.new_in_area  = centre;
      rep.new_owner    = owner_mid[cx];
      if (refine_reg == TASK_HOLLOW && may_join && n4 >= HOLLOW_MIN) begin
         rep.new_in_area = 1'b1;
         rep.new_owner   = own_reg;
      end else if (refine_reg == TASK_SPIKE && inner && n4 <= SPIKE_MAX) begin
         rep.new_in_area = 1'b0;
         rep.new_owner   = '0;
      end else if (refine_reg == TASK_EXPAND && may_join) begin
         rep.new_in_area = 1'b1;
         rep.new_owner   = own_reg;
      end
      return rep;
   endfunction

   // one accepted stream item: advance the window and queue what it releases
   function automatic void take_item(logic [REQ_TDATA_W-1:0] d, logic pad);
      int w;
      int h;
      int x;
      int y;
      w = active_width();
      h = active_height();
      x = col_pos;
      y = row_pos;
      // flush item at the very start of a frame is dropped
      if (pad && x == 0 && y == 0) return;
      if (x == 0) begin
         if (y >= 2 && y - 2 < h) expected_reports.push_back(predict_report(w - 1, y - 2));
         for (int i = 0; i < MAX_W; i++) begin
            mask_above[i] = mask_mid[i];
            mask_mid[i]   = mask_low[i];
            owner_mid[i]  = owner_low[i];
            allow_mid[i]  = allow_low[i];
         end
      end
      // padding inside the map stands for an all-zero pixel
      if (y < h && x < w) begin
         mask_low[x]  = pad ? 1'b0 : d[REQ_IN_AREA_BIT];
         allow_low[x] = pad ? 1'b0 : d[REQ_ALLOWED_BIT];
         owner_low[x] = pad ? '0 : d[REQ_OWNER_LSB +: FIELD_OWNER_W];
      end
      if (x >= 1 && y >= 1 && y - 1 < h) expected_reports.push_back(predict_report(x - 1, y - 1));
      if (x == 0 && y >= h + 1) begin
         col_pos = 0;
         row_pos = 0;
      end else begin
         x++;
         if (x >= w) begin
            x = 0;
            y++;
         end
         col_pos = x;
         row_pos = y;
      end
   endfunction

   function automatic void apply_write(logic [CSR_INDEX_W-1:0] idx, logic [CSR_DATA_W-1:0] val);
      case (idx)
         CSR_MAP_WIDTH: begin
            width_reg = val;
            col_pos   = 0;
            row_pos   = 0;
         end
         CSR_MAP_HEIGHT: begin
            height_reg = val;
            col_pos    = 0;
            row_pos    = 0;
         end
         CSR_DIAGONAL_MODE: diag_reg = val[0];
         CSR_REFINE_TASK: refine_reg = refine_task_type'(val[1:0]);
         CSR_OWN_INDEX: own_reg = val[FIELD_OWNER_W-1:0];
         default: ;
      endcase
   endfunction

   function automatic void restore_defaults();
      width_reg  = MAP_WIDTH_RST;
      height_reg = MAP_HEIGHT_RST;
      diag_reg   = 1'b0;
      refine_reg = TASK_NONE;
      own_reg    = OWN_INDEX_RST;
      col_pos    = 0;
      row_pos    = 0;
      for (int i = 0; i < MAX_W; i++) begin
         mask_above[i] = 1'b0;
         mask_mid[i]   = 1'b0;
         mask_low[i]   = 1'b0;
         owner_mid[i]  = '0;
         owner_low[i]  = '0;
         allow_mid[i]  = 1'b0;
         allow_low[i]  = 1'b0;
      end
      expected_reports.delete();
   endfunction

   // compare one result transfer against the oldest expectation
   function automatic void check_report(logic [RSP_TDATA_W-1:0] d);
      pixel_report_t got;
      pixel_report_t want;
      got.pos_x        = d[FIELD_POS_W-1:0];
      got.pos_y        = d[POS_Y_LSB +: FIELD_POS_W];
      got.inner_edge   = d[INNER_BIT];
      got.outside_edge = d[OUTSIDE_BIT];
      got.new_in_area  = d[NEW_AREA_BIT];
      got.new_owner    = d[NEW_OWNER_LSB +: FIELD_OWNER_W];
      if (expected_reports.size() == 0) begin
         if (fail_count < 10)
            $display("unexpected pixel report: x=%0d y=%0d inner=%0b outside=%0b area=%0b owner=%0d",
                     got.pos_x, got.pos_y, got.inner_edge, got.outside_edge,
                     got.new_in_area, got.new_owner);
         fail_count++;
         return;
      end
      want = expected_reports.pop_front();
      if (got.pos_x !== want.pos_x || got.pos_y !== want.pos_y
          || got.inner_edge !== want.inner_edge || got.outside_edge !== want.outside_edge
          || got.new_in_area !== want.new_in_area || got.new_owner !== want.new_owner) begin
         if (fail_count < 10) begin
            $display("pixel report differs: expected x=%0d y=%0d inner=%0b outside=%0b area=%0b owner=%0d",
                     want.pos_x, want.pos_y, want.inner_edge, want.outside_edge,
                     want.new_in_area, want.new_owner);
            $display("                      actual   x=%0d y=%0d inner=%0b outside=%0b area=%0b owner=%0d",
                     got.pos_x, got.pos_y, got.inner_edge, got.outside_edge,
                     got.new_in_area, got.new_owner);
         end
         fail_count++;
      end
   endfunction

   // sample every channel at the clock edge
   always @(posedge clock) begin
      if (reset) begin
         restore_defaults();
      end else begin
         if (rsp_tvalid && rsp_tready) check_report(rsp_tdata);
         if (csr_we) apply_write(csr_index, csr_wdata);
         if (req_tvalid && req_tready) take_item(req_tdata, req_tuser[REQ_PAD_BIT]);
      end
      waiting_copy <= expected_reports.size();
   end

endmodule

### bench/tb_top.sv
// Testbench top for the mask edge refine core: stimulus, stalls and verdict
`timescale 1ns / 1ps

module tb_top;
   import bmer_pkg::*;

   localparam int MAX_W        = 256;
   localparam int RANDOM_ITEMS = 600;
   localparam int SETTLE       = 8;
   localparam int IDLE_LIMIT   = 2000;

   logic                   clock      = 1'b0;
   logic                   reset      = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata  = '0;
   logic [REQ_TUSER_W-1:0] req_tuser  = '0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0] rsp_tdata;
   logic                   csr_we     = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index  = '0;
   logic [CSR_DATA_W-1:0]  csr_wdata  = '0;
   int                     fail_total;
   int                     reports_waiting;

   // stimulus state
   int   cur_own       = 1;
   int   cur_w         = 64;
   int   cur_h         = 64;
   logic steady        = 1'b0;
   int   counted_items = 0;
   int   ready_hold    = 0;
   int   ready_pick;
   int   idle_cycles   = 0;

   binary_mask_edge_refine_core #(
      .MAX_WIDTH  (MAX_W),
      .OWNER_BITS (FIELD_OWNER_W)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   mask_edge_checker #(
      .MAX_W (MAX_W)
   ) edge_check (
      .clock           (clock),
      .reset           (reset),
      .req_tvalid      (req_tvalid),
      .req_tready      (req_tready),
      .req_tdata       (req_tdata),
      .req_tuser       (req_tuser),
      .rsp_tvalid      (rsp_tvalid),
      .rsp_tready      (rsp_tready),
      .rsp_tdata       (rsp_tdata),
      .csr_we          (csr_we),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .fail_total      (fail_total),
      .reports_waiting (reports_waiting)
   );

   // 2 ns clock
   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // result side stalls: mostly short, a few long, some long ready stretches
   always @(posedge clock) begin
      if (ready_hold > 0) begin
         ready_hold <= ready_hold - 1;
      end else begin
         ready_pick = $urandom_range(0, 99);
         if (ready_pick < 5) begin
            rsp_tready <= 1'b1;
            ready_hold <= $urandom_range(100, 200);
         end else if (ready_pick < 60) begin
            rsp_tready <= 1'b1;
            ready_hold <= $urandom_range(0, 20);
         end else if (ready_pick < 92) begin
            rsp_tready <= 1'b0;
            ready_hold <= $urandom_range(0, 3);
         end else begin
            rsp_tready <= 1'b0;
            ready_hold <= $urandom_range(10, 30);
         end
      end
   end

   // watchdog on cycles with no transfer at all
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || csr_we) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   function automatic logic [REQ_TDATA_W-1:0] pixel_word(logic in_area, logic allowed,
                                                        logic [FIELD_OWNER_W-1:0] owner);
      logic [REQ_TDATA_W-1:0] w;
      w = '0;
      w[REQ_IN_AREA_BIT] = in_area;
      w[REQ_ALLOWED_BIT] = allowed;
      w[REQ_OWNER_LSB +: FIELD_OWNER_W] = owner;
      return w;
   endfunction

   // owner biased towards 0 and the own index so that joins happen
   function automatic logic [REQ_TDATA_W-1:0] random_pixel(int density);
      logic [FIELD_OWNER_W-1:0] owner;
      case ($urandom_range(0, 3))
         0: owner = '0;
         1: owner = FIELD_OWNER_W'(cur_own);
         default: owner = FIELD_OWNER_W'($urandom_range(0, 255));
      endcase
      return pixel_word($urandom_range(0, 99) < density, $urandom_range(0, 3) != 0, owner);
   endfunction

   function automatic int pick_gap();
      int r;
      if (steady) return 0;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(10, 30);
   endfunction

   // one request transfer, with an optional idle gap in front
   task automatic send_item(logic [REQ_TDATA_W-1:0] d, logic pad);
      int                     gap;
      logic [REQ_TUSER_W-1:0] u;
      gap = pick_gap();
      u = '0;
      u[REQ_PAD_BIT] = pad;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= d;
      req_tuser  <= u;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   // wait until every expected report has left, then let the pipe settle
   task automatic drain();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (reports_waiting != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_reg(csr_index_type idx, int val);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= CSR_DATA_W'(val);
      @(posedge clock);
   endtask

   task automatic setup(int w_raw, int h_raw, logic diag, refine_task_type code, int own,
                        logic with_size);
      drain();
      if (with_size) begin
         write_reg(CSR_MAP_WIDTH, w_raw);
         write_reg(CSR_MAP_HEIGHT, h_raw);
         cur_w = (w_raw == 0) ? 1 : (w_raw > MAX_W) ? MAX_W : w_raw;
         cur_h = (h_raw == 0) ? 1 : (h_raw > MAX_HEIGHT) ? MAX_HEIGHT : h_raw;
      end
      write_reg(CSR_DIAGONAL_MODE, int'(diag));
      write_reg(CSR_REFINE_TASK, int'(code));
      write_reg(CSR_OWN_INDEX, own);
      csr_we  <= 1'b0;
      cur_own = own;
   endtask

   // a frame of random pixels and its flush, optionally cut short
   task automatic send_frame(int density, int cut_at);
      int   total;
      logic pad;
      total  = cur_w * cur_h + cur_w + 1;
      steady = ($urandom_range(0, 3) == 0);
      // flush item at frame start, dropped by the block
      if ($urandom_range(0, 7) == 0) send_item(random_pixel(density), 1'b1);
      for (int k = 0; k < total; k++) begin
         if (cut_at >= 0 && k >= cut_at) break;
         counted_items++;
         // a few padding items inside the map, a few pixels among the flush
         if (k < cur_w * cur_h) pad = ($urandom_range(0, 19) == 0);
         else pad = ($urandom_range(0, 9) != 0);
         send_item(random_pixel(density), pad);
      end
   endtask

   initial begin
      int              phase;
      int              frames;
      int              cut;
      int              w_raw;
      int              h_raw;
      int              own;
      int              density;
      int              r;
      logic            with_size;
      logic            cut_last;
      refine_task_type code;

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // 3x3 ring around an allowed unowned hole: the hole is filled
      setup(3, 3, 1'b0, TASK_HOLLOW, 1, 1'b1);
      send_item(pixel_word(1'b0, 1'b1, 8'hFF), 1'b1);
      send_item(pixel_word(1'b1, 1'b1, 8'hFF), 1'b0);
      send_item(pixel_word(1'b1, 1'b0, 8'h00), 1'b0);
      send_item(pixel_word(1'b1, 1'b1, 8'h01), 1'b0);
      send_item(pixel_word(1'b1, 1'b0, 8'h80), 1'b0);
      send_item(pixel_word(1'b0, 1'b1, 8'h00), 1'b0);
      send_item(pixel_word(1'b1, 1'b1, 8'h7F), 1'b0);
      send_item(pixel_word(1'b1, 1'b0, 8'h00), 1'b0);
      send_item(pixel_word(1'b1, 1'b1, 8'hAA), 1'b0);
      send_item(pixel_word(1'b1, 1'b1, 8'h55), 1'b0);
      repeat (4) send_item(pixel_word(1'b1, 1'b1, 8'hFF), 1'b1);

      // zero width used as one, eight neighbours, spikes removed, pixel inside flush
      setup(0, 2, 1'b1, TASK_SPIKE, 1, 1'b1);
      send_item(pixel_word(1'b1, 1'b1, 8'h00), 1'b0);
      send_item(pixel_word(1'b1, 1'b0, 8'h03), 1'b0);
      send_item(pixel_word(1'b1, 1'b0, 8'h5A), 1'b0);
      send_item(pixel_word(1'b0, 1'b0, 8'h00), 1'b1);

      // expand with the top own index, padding inside the map as a zero pixel
      setup(2, 2, 1'b0, TASK_EXPAND, 255, 1'b1);
      send_item(pixel_word(1'b1, 1'b0, 8'h00), 1'b0);
      send_item(pixel_word(1'b0, 1'b1, 8'hFF), 1'b0);
      send_item(pixel_word(1'b1, 1'b1, 8'h3C), 1'b1);
      send_item(pixel_word(1'b0, 1'b1, 8'h07), 1'b0);
      repeat (3) send_item(pixel_word(1'b0, 1'b0, 8'h00), 1'b1);

      // random phases: new settings, then one to three frames
      phase    = 0;
      cut_last = 1'b0;
      while (counted_items < RANDOM_ITEMS) begin
         if (phase == 2) begin
            w_raw = 511;
            h_raw = 1;
         end else if (phase == 5) begin
            w_raw = 1;
            h_raw = 256;
         end else if (phase == 8) begin
            w_raw = 0;
            h_raw = 300;
         end else begin
            r = $urandom_range(0, 99);
            w_raw = (r < 6) ? 0 : (r < 14) ? 1 : $urandom_range(2, 12);
            r = $urandom_range(0, 99);
            h_raw = (r < 6) ? 0 : (r < 14) ? 1 : $urandom_range(2, 8);
         end
         with_size = (phase == 2 || phase == 5 || phase == 8 || cut_last
                      || $urandom_range(0, 3) != 0);
         r = $urandom_range(0, 99);
         own = (r < 15) ? 1 : (r < 30) ? 255 : $urandom_range(1, 255);
         code = refine_task_type'($urandom_range(0, 3));
         setup(w_raw, h_raw, $urandom_range(0, 1), code, own, with_size);

         frames = (phase == 2 || phase == 5) ? 1 : $urandom_range(1, 3);
         cut = -1;
         for (int f = 0; f < frames; f++) begin
            case ($urandom_range(0, 3))
               0: density = 15;
               1: density = 50;
               2: density = 85;
               default: density = 100;
            endcase
            // a broken frame now and then, restarted by the next size write
            if (f == frames - 1 && phase == 8) cut = $urandom_range(20, 60);
            else if (f == frames - 1 && phase != 2 && phase != 5 && $urandom_range(0, 6) == 0)
               cut = $urandom_range(1, cur_w * cur_h + cur_w);
            send_frame(density, cut);
         end
         cut_last = (cut >= 0);
         phase++;
      end

      drain();
      if (fail_total == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule

### binary_mask_edge_refine_core.f
rtl/core/bmer_pkg.sv
rtl/core/bmer_ram.sv
rtl/core/binary_mask_edge_refine_core.sv
bench/mask_edge_checker.sv
bench/tb_top.sv
